// File: design/qlic_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qlic_pkg: shared types and constants for the quadrant light imbalance check
// Item formats, threshold set, register indexes and divider staging.
// ----------------------------------------------------------------------------
package qlic_pkg;

	// Converter field width as carried on the ports
	localparam int FIELD_W            = 12;
	localparam int COUNT_BITS_DEFAULT = 12;

	// Balance format: signed Q2.14
	localparam int FRAC_BITS = 14;
	localparam int QUO_W     = FRAC_BITS + 1;
	localparam int BAL_W     = 16;
	localparam int BAL_MAX   = 1 << FRAC_BITS;

	// Quotient bits resolved per divider stage
	localparam int DIV_STEPS = 4;

	// Threshold register widths and reset values
	localparam int MIN_TOTAL_W  = 14;
	localparam int SAT_W        = 12;
	localparam int OPEN_W       = 12;
	localparam int SHORT_W      = 13;
	localparam int CFG_DATA_W   = 14;
	localparam int CFG_IDX_W    = 2;

	localparam logic [MIN_TOTAL_W-1:0] MIN_TOTAL_RST = MIN_TOTAL_W'(100);
	localparam logic [SAT_W-1:0]       SAT_RST       = SAT_W'(4000);
	localparam logic [OPEN_W-1:0]      OPEN_RST      = OPEN_W'(0);
	localparam logic [SHORT_W-1:0]     SHORT_RST     = SHORT_W'(4095);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_TOTAL  = 2'd0,
		REG_SATURATION = 2'd1,
		REG_OPEN       = 2'd2,
		REG_SHORT      = 2'd3
	} cfg_index_t;

	typedef struct packed {
		logic [MIN_TOTAL_W-1:0] min_total_count;
		logic [SAT_W-1:0]       saturation_count;
		logic [OPEN_W-1:0]      open_count;
		logic [SHORT_W-1:0]     short_count;
	} cfg_t;

	typedef struct packed {
		logic [FIELD_W-1:0] top_left;
		logic [FIELD_W-1:0] top_right;
		logic [FIELD_W-1:0] bottom_left;
		logic [FIELD_W-1:0] bottom_right;
	} in_item_t;

	typedef struct packed {
		logic signed [BAL_W-1:0] pitch_balance;
		logic signed [BAL_W-1:0] roll_balance;
		logic                    too_dark;
		logic                    saturated;
		logic                    channel_open;
		logic                    channel_short;
	} out_item_t;

	// Sign, zero-total and fault flags riding along the divider pipe
	typedef struct packed {
		logic neg_p;
		logic neg_r;
		logic zero;
		logic too_dark;
		logic saturated;
		logic channel_open;
		logic channel_short;
	} ctl_t;

endpackage

// File: design/qlic_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qlic_front: first pipeline stage
// Forms quadrant sums and total, evaluates fault flags, takes balance
// magnitudes and resolves the integer quotient bit of both divisions.
// ----------------------------------------------------------------------------
module qlic_front #(
	parameter int COUNT_BITS = qlic_pkg::COUNT_BITS_DEFAULT
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  qlic_pkg::cfg_t                         cfg,
	input  logic                                   valid_i,
	output logic                                   ready_o,
	input  qlic_pkg::in_item_t                     item_i,
	output logic                                   valid_o,
	input  logic                                   ready_i,
	output logic [((COUNT_BITS < qlic_pkg::FIELD_W) ? COUNT_BITS : qlic_pkg::FIELD_W)+1:0] rem_p_o,
	output logic [((COUNT_BITS < qlic_pkg::FIELD_W) ? COUNT_BITS : qlic_pkg::FIELD_W)+1:0] rem_r_o,
	output logic [((COUNT_BITS < qlic_pkg::FIELD_W) ? COUNT_BITS : qlic_pkg::FIELD_W)+1:0] total_o,
	output logic [qlic_pkg::QUO_W-1:0]             quo_p_o,
	output logic [qlic_pkg::QUO_W-1:0]             quo_r_o,
	output qlic_pkg::ctl_t                         ctl_o
);
	import qlic_pkg::*;

	localparam int CH_W  = (COUNT_BITS < FIELD_W) ? COUNT_BITS : FIELD_W;
	localparam int SUM_W = CH_W + 1;
	localparam int TOT_W = CH_W + 2;

	logic [CH_W-1:0]  ch [4];
	logic [SUM_W-1:0] top_sum, bot_sum, left_sum, right_sum;
	logic [SUM_W-1:0] mag_p, mag_r;
	logic [TOT_W-1:0] total;
	logic             eq_p, eq_r;
	logic             sat_any, open_any, short_any;
	ctl_t             ctl_next;

	logic             valid_s1;
	logic [TOT_W-1:0] rem_p_s1, rem_r_s1, total_s1;
	logic [QUO_W-1:0] quo_p_s1, quo_r_s1;
	ctl_t             ctl_s1;

	// Keep the low converter bits of each channel
	assign ch[0] = CH_W'(item_i.top_left);
	assign ch[1] = CH_W'(item_i.top_right);
	assign ch[2] = CH_W'(item_i.bottom_left);
	assign ch[3] = CH_W'(item_i.bottom_right);

	// Quadrant sums and total
	assign top_sum   = SUM_W'(ch[0]) + SUM_W'(ch[1]);
	assign bot_sum   = SUM_W'(ch[2]) + SUM_W'(ch[3]);
	assign left_sum  = SUM_W'(ch[0]) + SUM_W'(ch[2]);
	assign right_sum = SUM_W'(ch[1]) + SUM_W'(ch[3]);
	assign total     = TOT_W'(top_sum) + TOT_W'(bot_sum);

	// Sign and magnitude of each difference
	always_comb begin
		ctl_next = '0;
		ctl_next.neg_p = top_sum < bot_sum;
		ctl_next.neg_r = left_sum < right_sum;
		mag_p = ctl_next.neg_p ? (bot_sum - top_sum) : (top_sum - bot_sum);
		mag_r = ctl_next.neg_r ? (right_sum - left_sum) : (left_sum - right_sum);

		// Per-channel threshold checks
		sat_any   = 1'b0;
		open_any  = 1'b0;
		short_any = 1'b0;
		for (int i = 0; i < 4; i++) begin
			sat_any   = sat_any   | (SAT_W'(ch[i]) > cfg.saturation_count);
			open_any  = open_any  | (OPEN_W'(ch[i]) <= cfg.open_count);
			short_any = short_any | (SHORT_W'(ch[i]) >= cfg.short_count);
		end

		ctl_next.zero          = total == '0;
		ctl_next.too_dark      = MIN_TOTAL_W'(total) < cfg.min_total_count;
		ctl_next.saturated     = sat_any;
		ctl_next.channel_open  = open_any & ~ctl_next.too_dark;
		ctl_next.channel_short = short_any;
	end

	// Integer quotient bit: magnitude never exceeds total
	assign eq_p = TOT_W'(mag_p) == total;
	assign eq_r = TOT_W'(mag_r) == total;

	// Advance when the next stage can take the item or this stage is empty
	assign ready_o = ~valid_s1 | ready_i;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_o) begin
			valid_s1 <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_o && valid_i) begin
			rem_p_s1 <= eq_p ? '0 : TOT_W'(mag_p);
			rem_r_s1 <= eq_r ? '0 : TOT_W'(mag_r);
			quo_p_s1 <= QUO_W'(eq_p);
			quo_r_s1 <= QUO_W'(eq_r);
			total_s1 <= total;
			ctl_s1   <= ctl_next;
		end
	end

	assign valid_o = valid_s1;
	assign rem_p_o = rem_p_s1;
	assign rem_r_o = rem_r_s1;
	assign total_o = total_s1;
	assign quo_p_o = quo_p_s1;
	assign quo_r_o = quo_r_s1;
	assign ctl_o   = ctl_s1;

endmodule

// File: design/qlic_div_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qlic_div_stage: one restoring-division pipeline stage
// Resolves STEPS fraction bits of the pitch and roll quotients in parallel.
// ----------------------------------------------------------------------------
module qlic_div_stage #(
	parameter int COUNT_BITS = qlic_pkg::COUNT_BITS_DEFAULT,
	parameter int STEPS      = qlic_pkg::DIV_STEPS
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   valid_i,
	output logic                                   ready_o,
	input  logic [((COUNT_BITS < qlic_pkg::FIELD_W) ? COUNT_BITS : qlic_pkg::FIELD_W)+1:0] rem_p_i,
	input  logic [((COUNT_BITS < qlic_pkg::FIELD_W) ? COUNT_BITS : qlic_pkg::FIELD_W)+1:0] rem_r_i,
	input  logic [((COUNT_BITS < qlic_pkg::FIELD_W) ? COUNT_BITS : qlic_pkg::FIELD_W)+1:0] total_i,
	input  logic [qlic_pkg::QUO_W-1:0]             quo_p_i,
	input  logic [qlic_pkg::QUO_W-1:0]             quo_r_i,
	input  qlic_pkg::ctl_t                         ctl_i,
	output logic                                   valid_o,
	input  logic                                   ready_i,
	output logic [((COUNT_BITS < qlic_pkg::FIELD_W) ? COUNT_BITS : qlic_pkg::FIELD_W)+1:0] rem_p_o,
	output logic [((COUNT_BITS < qlic_pkg::FIELD_W) ? COUNT_BITS : qlic_pkg::FIELD_W)+1:0] rem_r_o,
	output logic [((COUNT_BITS < qlic_pkg::FIELD_W) ? COUNT_BITS : qlic_pkg::FIELD_W)+1:0] total_o,
	output logic [qlic_pkg::QUO_W-1:0]             quo_p_o,
	output logic [qlic_pkg::QUO_W-1:0]             quo_r_o,
	output qlic_pkg::ctl_t                         ctl_o
);
	import qlic_pkg::*;

	localparam int CH_W  = (COUNT_BITS < FIELD_W) ? COUNT_BITS : FIELD_W;
	localparam int TOT_W = CH_W + 2;

	logic [TOT_W-1:0] rp, rr;
	logic [TOT_W:0]   sp, sr, dv;
	logic [QUO_W-1:0] qp, qr;

	logic             valid_sd;
	logic [TOT_W-1:0] rem_p_sd, rem_r_sd, total_sd;
	logic [QUO_W-1:0] quo_p_sd, quo_r_sd;
	ctl_t             ctl_sd;

	// Shift, compare and subtract once per quotient bit
	always_comb begin
		dv = {1'b0, total_i};
		rp = rem_p_i;
		rr = rem_r_i;
		qp = quo_p_i;
		qr = quo_r_i;
		sp = '0;
		sr = '0;
		for (int i = 0; i < STEPS; i++) begin
			sp = {rp, 1'b0};
			sr = {rr, 1'b0};
			if (sp >= dv) begin
				rp = TOT_W'(sp - dv);
				qp = {qp[QUO_W-2:0], 1'b1};
			end else begin
				rp = sp[TOT_W-1:0];
				qp = {qp[QUO_W-2:0], 1'b0};
			end
			if (sr >= dv) begin
				rr = TOT_W'(sr - dv);
				qr = {qr[QUO_W-2:0], 1'b1};
			end else begin
				rr = sr[TOT_W-1:0];
				qr = {qr[QUO_W-2:0], 1'b0};
			end
		end
	end

	// Hold on stall, advance otherwise
	assign ready_o = ~valid_sd | ready_i;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sd <= 1'b0;
		end else if (ready_o) begin
			valid_sd <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_o && valid_i) begin
			rem_p_sd <= rp;
			rem_r_sd <= rr;
			quo_p_sd <= qp;
			quo_r_sd <= qr;
			total_sd <= total_i;
			ctl_sd   <= ctl_i;
		end
	end

	assign valid_o = valid_sd;
	assign rem_p_o = rem_p_sd;
	assign rem_r_o = rem_r_sd;
	assign total_o = total_sd;
	assign quo_p_o = quo_p_sd;
	assign quo_r_o = quo_r_sd;
	assign ctl_o   = ctl_sd;

endmodule

// File: design/quadrant_light_imbalance_check_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadrant_light_imbalance_check_top: quadrant sun sensor imbalance check
//
//   Port group   Direction  Handshake          Payload
//   in_*         in         in_valid/in_stall  in_item   (four converter counts)
//   out_*        out        out_valid/out_stall out_item (balances and flags)
//   cfg_*        in         cfg_wr_en          cfg_index, cfg_data
//
// Takes one item per clock while in_stall is low. Stages, in order: one stage
// for sums and flags, a chain of restoring-division stages that each resolve
// up to DIV_STEPS quotient bits (the last takes the remainder), and the output register.
// Stall ripples back through the per-stage ready chain; bubbles are squeezed
// out. Reset clears every valid bit and loads the threshold reset values.
// ----------------------------------------------------------------------------
module quadrant_light_imbalance_check_top #(
	parameter int COUNT_BITS = qlic_pkg::COUNT_BITS_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  qlic_pkg::in_item_t                in_item,
	output logic                              out_valid,
	input  logic                              out_stall,
	output qlic_pkg::out_item_t               out_item,
	input  logic                              cfg_wr_en,
	input  logic [qlic_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [qlic_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import qlic_pkg::*;

	localparam int CH_W    = (COUNT_BITS < FIELD_W) ? COUNT_BITS : FIELD_W;
	localparam int TOT_W   = CH_W + 2;
	localparam int NUM_DIV = (FRAC_BITS + DIV_STEPS - 1) / DIV_STEPS;

	cfg_t             cfg_q;
	logic             front_ready;

	logic             d_valid [0:NUM_DIV];
	logic             d_ready [0:NUM_DIV];
	logic [TOT_W-1:0] d_rem_p [0:NUM_DIV];
	logic [TOT_W-1:0] d_rem_r [0:NUM_DIV];
	logic [TOT_W-1:0] d_total [0:NUM_DIV];
	logic [QUO_W-1:0] d_quo_p [0:NUM_DIV];
	logic [QUO_W-1:0] d_quo_r [0:NUM_DIV];
	ctl_t             d_ctl   [0:NUM_DIV];

	logic             out_ready;
	logic [BAL_W-1:0] mag_p, mag_r;
	out_item_t        out_next;
	logic             out_valid_so;
	out_item_t        out_item_so;

	// Threshold registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_total_count  <= MIN_TOTAL_RST;
			cfg_q.saturation_count <= SAT_RST;
			cfg_q.open_count       <= OPEN_RST;
			cfg_q.short_count      <= SHORT_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_MIN_TOTAL:  cfg_q.min_total_count  <= cfg_data[MIN_TOTAL_W-1:0];
				REG_SATURATION: cfg_q.saturation_count <= cfg_data[SAT_W-1:0];
				REG_OPEN:       cfg_q.open_count       <= cfg_data[OPEN_W-1:0];
				REG_SHORT:      cfg_q.short_count      <= cfg_data[SHORT_W-1:0];
				default: ;
			endcase
		end
	end

	// Sums, flags and integer quotient bit
	qlic_front #(
		.COUNT_BITS(COUNT_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.valid_i (in_valid),
		.ready_o (front_ready),
		.item_i  (in_item),
		.valid_o (d_valid[0]),
		.ready_i (d_ready[0]),
		.rem_p_o (d_rem_p[0]),
		.rem_r_o (d_rem_r[0]),
		.total_o (d_total[0]),
		.quo_p_o (d_quo_p[0]),
		.quo_r_o (d_quo_r[0]),
		.ctl_o   (d_ctl[0])
	);

	assign in_stall = ~front_ready;

	// Fraction bits, DIV_STEPS per stage, last stage takes the remainder
	for (genvar s = 0; s < NUM_DIV; s++) begin : g_div
		localparam int LEFT  = FRAC_BITS - s * DIV_STEPS;
		localparam int STEPS = (LEFT < DIV_STEPS) ? LEFT : DIV_STEPS;

		qlic_div_stage #(
			.COUNT_BITS(COUNT_BITS),
			.STEPS     (STEPS)
		) u_div (
			.clk     (clk),
			.arst_n  (arst_n),
			.valid_i (d_valid[s]),
			.ready_o (d_ready[s]),
			.rem_p_i (d_rem_p[s]),
			.rem_r_i (d_rem_r[s]),
			.total_i (d_total[s]),
			.quo_p_i (d_quo_p[s]),
			.quo_r_i (d_quo_r[s]),
			.ctl_i   (d_ctl[s]),
			.valid_o (d_valid[s+1]),
			.ready_i (d_ready[s+1]),
			.rem_p_o (d_rem_p[s+1]),
			.rem_r_o (d_rem_r[s+1]),
			.total_o (d_total[s+1]),
			.quo_p_o (d_quo_p[s+1]),
			.quo_r_o (d_quo_r[s+1]),
			.ctl_o   (d_ctl[s+1])
		);
	end

	// Apply sign, force zero balance on an empty total
	always_comb begin
		mag_p = BAL_W'(d_quo_p[NUM_DIV]);
		mag_r = BAL_W'(d_quo_r[NUM_DIV]);
		out_next = '0;
		if (!d_ctl[NUM_DIV].zero) begin
			out_next.pitch_balance = d_ctl[NUM_DIV].neg_p ? -mag_p : mag_p;
			out_next.roll_balance  = d_ctl[NUM_DIV].neg_r ? -mag_r : mag_r;
		end
		out_next.too_dark      = d_ctl[NUM_DIV].too_dark;
		out_next.saturated     = d_ctl[NUM_DIV].saturated;
		out_next.channel_open  = d_ctl[NUM_DIV].channel_open;
		out_next.channel_short = d_ctl[NUM_DIV].channel_short;
	end

	// Output register
	assign out_ready        = ~out_valid_so | ~out_stall;
	assign d_ready[NUM_DIV] = out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_so <= 1'b0;
		end else if (out_ready) begin
			out_valid_so <= d_valid[NUM_DIV];
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready && d_valid[NUM_DIV]) begin
			out_item_so <= out_next;
		end
	end

	assign out_valid = out_valid_so;
	assign out_item  = out_item_so;

	// An empty output register means the whole chain is ready
	a_no_stall_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output register");

	// A dark reading never reports an open channel
	a_dark_not_open: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_item.too_dark && out_item.channel_open))
		else $error("open flag set on a dark reading");

	// Balances stay within one full scale
	a_pitch_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_item.pitch_balance >= BAL_W'(-BAL_MAX)) &&
			(out_item.pitch_balance <= BAL_W'(BAL_MAX)))
		else $error("pitch balance out of range");

	a_roll_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_item.roll_balance >= BAL_W'(-BAL_MAX)) &&
			(out_item.roll_balance <= BAL_W'(BAL_MAX)))
		else $error("roll balance out of range");

endmodule

// File: tb/tb_quadrant_light_imbalance_check_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quadrant_light_imbalance_check_top: quadrant light imbalance checker bench
// Drives four-channel readings through the valid/stall input and compares
// every output item with a local imbalance and fault-flag predictor. Covers
// directed corner readings, then random readings under several threshold
// sets, random idling on both sides, and two long output hold-offs.
// ----------------------------------------------------------------------------
module tb_quadrant_light_imbalance_check_top;
	import qlic_pkg::*;

	localparam int COUNT_BITS   = COUNT_BITS_DEFAULT;
	localparam int HALF_PERIOD  = 10;
	localparam int RESET_CYCLES = 6;
	localparam int PHASE_ITEMS  = 165;
	localparam int TAIL_CYCLES  = 20;
	localparam int QUIET_LIMIT  = 5000;
	localparam int HOLD_CYCLES  = 60;
	localparam int HOLD_AT_1    = 200;
	localparam int HOLD_AT_2    = 750;
	localparam int PRINT_LIMIT  = 100;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	in_item_t              in_item = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	out_item_t             out_item;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Predictor copy of the thresholds
	cfg_t thr = '{min_total_count: MIN_TOTAL_RST, saturation_count: SAT_RST,
		open_count: OPEN_RST, short_count: SHORT_RST};

	in_item_t  reading_q[$];
	out_item_t imbalance_q[$];

	int   tx_idle_pct = 13;
	int   rx_idle_pct = 77;
	int   n_queued = 0;
	int   n_in = 0;
	int   n_out = 0;
	int   errors = 0;
	logic in_took = 1'b0;
	int   hold_left = 0;
	int   holds_done = 0;
	int   quiet = 0;
	int   seen = 0;

	quadrant_light_imbalance_check_top #(.COUNT_BITS(COUNT_BITS)) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #HALF_PERIOD clk = ~clk;

	// (a - b) * 2^14 / total, truncated toward zero, zero on empty total
	function automatic logic [BAL_W-1:0] q14_ratio(int unsigned a, int unsigned b,
			int unsigned total);
		int unsigned mag;
		logic [BAL_W-1:0] q;
		if (total == 0)
			return '0;
		mag = (a >= b) ? a - b : b - a;
		q = BAL_W'((mag << FRAC_BITS) / total);
		if (a < b)
			q = ~q + BAL_W'(1);
		return q;
	endfunction

	// Balances and fault flags for one reading under the current thresholds
	function automatic out_item_t compute_imbalance(in_item_t rd);
		int unsigned ch[4];
		int unsigned top, bottom, left, right, total;
		out_item_t r;
		logic open_any;
		ch[0] = int'(rd.top_left) & ((1 << COUNT_BITS) - 1);
		ch[1] = int'(rd.top_right) & ((1 << COUNT_BITS) - 1);
		ch[2] = int'(rd.bottom_left) & ((1 << COUNT_BITS) - 1);
		ch[3] = int'(rd.bottom_right) & ((1 << COUNT_BITS) - 1);
		top = ch[0] + ch[1];
		bottom = ch[2] + ch[3];
		left = ch[0] + ch[2];
		right = ch[1] + ch[3];
		total = top + bottom;
		r = '0;
		open_any = 1'b0;
		r.pitch_balance = q14_ratio(top, bottom, total);
		r.roll_balance = q14_ratio(left, right, total);
		r.too_dark = total < int'(thr.min_total_count);
		for (int i = 0; i < 4; i++) begin
			if (ch[i] > int'(thr.saturation_count))
				r.saturated = 1'b1;
			if (ch[i] <= int'(thr.open_count))
				open_any = 1'b1;
			if (ch[i] >= int'(thr.short_count))
				r.channel_short = 1'b1;
		end
		r.channel_open = !r.too_dark && open_any;
		return r;
	endfunction

	// One channel count, biased toward extremes and the live thresholds
	function automatic logic [FIELD_W-1:0] pick_count();
		int r;
		int v;
		r = $urandom_range(99);
		if (r < 35)
			return FIELD_W'($urandom_range(4095));
		if (r < 50) begin
			case ($urandom_range(3))
				0: return 12'd0;
				1: return 12'd1;
				2: return 12'd4094;
				default: return 12'd4095;
			endcase
		end
		if (r < 60)
			return FIELD_W'($urandom_range(15));
		case ($urandom_range(2))
			0: v = int'(thr.saturation_count);
			1: v = int'(thr.open_count);
			default: v = int'(thr.short_count);
		endcase
		v = v + $urandom_range(2) - 1;
		if (v < 0)
			v = 0;
		if (v > 4095)
			v = 4095;
		return FIELD_W'(v);
	endfunction

	// One random reading: balanced, empty, near the dark limit, or mixed
	function automatic in_item_t pick_reading();
		in_item_t rd;
		int r;
		int t;
		int q;
		r = $urandom_range(99);
		if (r < 5) begin
			rd = '0;
		end else if (r < 13) begin
			rd.top_left = pick_count();
			rd.top_right = rd.top_left;
			rd.bottom_left = rd.top_left;
			rd.bottom_right = rd.top_left;
		end else if (r < 23) begin
			t = int'(thr.min_total_count) + $urandom_range(2) - 1;
			if (t < 0)
				t = 0;
			if (t > 16380)
				t = 16380;
			q = t / 4;
			rd.top_left = FIELD_W'(q + int'((t % 4) > 0));
			rd.top_right = FIELD_W'(q + int'((t % 4) > 1));
			rd.bottom_left = FIELD_W'(q + int'((t % 4) > 2));
			rd.bottom_right = FIELD_W'(q);
		end else begin
			rd.top_left = pick_count();
			rd.top_right = pick_count();
			rd.bottom_left = pick_count();
			rd.bottom_right = pick_count();
		end
		return rd;
	endfunction

	task automatic report_error(string msg);
		if (errors < PRINT_LIMIT)
			$display("ERROR at %0t: %s", $realtime, msg);
		errors++;
	endtask

	task automatic queue_reading(int tl, int tr, int bl, int br);
		in_item_t rd;
		rd.top_left = FIELD_W'(tl);
		rd.top_right = FIELD_W'(tr);
		rd.bottom_left = FIELD_W'(bl);
		rd.bottom_right = FIELD_W'(br);
		reading_q.push_back(rd);
		n_queued++;
	endtask

	// Hold until every queued item went in and every result came out
	task automatic drain();
		while (n_in != n_queued || imbalance_q.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Write all four thresholds while idle; called at a falling edge
	task automatic set_thresholds(logic [CFG_DATA_W-1:0] min_total,
			logic [CFG_DATA_W-1:0] sat, logic [CFG_DATA_W-1:0] open_lim,
			logic [CFG_DATA_W-1:0] short_lim);
		logic [CFG_DATA_W-1:0] vals[4];
		cfg_index_t idx;
		vals = '{min_total, sat, open_lim, short_lim};
		for (int i = 0; i < 4; i++) begin
			idx = cfg_index_t'(i);
			cfg_wr_en <= 1'b1;
			cfg_index <= idx;
			cfg_data <= vals[i];
			case (idx)
				REG_MIN_TOTAL:  thr.min_total_count = vals[i][MIN_TOTAL_W-1:0];
				REG_SATURATION: thr.saturation_count = vals[i][SAT_W-1:0];
				REG_OPEN:       thr.open_count = vals[i][OPEN_W-1:0];
				REG_SHORT:      thr.short_count = vals[i][SHORT_W-1:0];
			endcase
			@(negedge clk);
		end
		cfg_wr_en <= 1'b0;
	endtask

	// Driver: offer the next pending item once the current one is taken
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_took)) begin
			if (reading_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
				in_item <= reading_q.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_item <= in_item_t'({12'($urandom), 12'($urandom), 12'($urandom),
					12'($urandom)});
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stall, plus two long hold-offs to back up the pipe
	always @(negedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else if ((holds_done == 0 && n_in >= HOLD_AT_1) ||
				(holds_done == 1 && n_in >= HOLD_AT_2)) begin
			out_stall <= 1'b1;
			hold_left = HOLD_CYCLES;
			holds_done = holds_done + 1;
		end else begin
			out_stall <= ($urandom_range(99) < rx_idle_pct);
		end
	end

	// Monitor: check taken outputs, predict taken inputs
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (imbalance_q.size() == 0) begin
					report_error($sformatf("output item %0d with nothing pending", n_out));
				end else begin
					want = imbalance_q.pop_front();
					if (out_item.pitch_balance !== want.pitch_balance)
						report_error($sformatf("item %0d pitch_balance %0d, want %0d", n_out,
							out_item.pitch_balance, want.pitch_balance));
					if (out_item.roll_balance !== want.roll_balance)
						report_error($sformatf("item %0d roll_balance %0d, want %0d", n_out,
							out_item.roll_balance, want.roll_balance));
					if (out_item.too_dark !== want.too_dark)
						report_error($sformatf("item %0d too_dark %b, want %b", n_out,
							out_item.too_dark, want.too_dark));
					if (out_item.saturated !== want.saturated)
						report_error($sformatf("item %0d saturated %b, want %b", n_out,
							out_item.saturated, want.saturated));
					if (out_item.channel_open !== want.channel_open)
						report_error($sformatf("item %0d channel_open %b, want %b", n_out,
							out_item.channel_open, want.channel_open));
					if (out_item.channel_short !== want.channel_short)
						report_error($sformatf("item %0d channel_short %b, want %b", n_out,
							out_item.channel_short, want.channel_short));
				end
				n_out++;
			end
			if (in_valid && !in_stall) begin
				imbalance_q.push_back(compute_imbalance(in_item));
				n_in++;
			end
		end
		in_took <= in_valid && !in_stall && arst_n;
	end

	// Watchdog: end the run when no item moves for too long
	always @(posedge clk) begin
		if (n_in + n_out != seen) begin
			seen = n_in + n_out;
			quiet = 0;
		end else begin
			quiet = quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// Stimulus sequence
	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Corner readings at reset thresholds
		queue_reading(0, 0, 0, 0);
		queue_reading(4095, 4095, 4095, 4095);
		queue_reading(4095, 0, 0, 0);
		queue_reading(0, 4095, 0, 0);
		queue_reading(0, 0, 4095, 0);
		queue_reading(0, 0, 0, 4095);
		queue_reading(1, 0, 0, 0);
		queue_reading(25, 25, 25, 25);
		queue_reading(25, 25, 25, 24);
		queue_reading(4000, 4000, 4000, 4000);
		queue_reading(4001, 3000, 2000, 1000);
		queue_reading(4094, 4094, 4094, 4094);
		queue_reading(3, 1, 2, 7);
		queue_reading('h555, 'hAAA, 'hAAA, 'h555);
		drain();

		// Nothing dark, nothing saturated, everything open, short disabled
		set_thresholds(14'd0, 14'd4095, 14'd4095, 14'd4096);
		queue_reading(0, 0, 0, 0);
		queue_reading(4095, 4095, 4095, 4095);
		queue_reading(1000, 7, 2048, 4095);
		drain();

		// Always dark, any light saturates, every channel shorted
		set_thresholds(14'd16383, 14'd0, 14'd0, 14'd0);
		queue_reading(4095, 4095, 4095, 4095);
		queue_reading(0, 0, 0, 0);
		queue_reading(1, 2, 3, 4);
		queue_reading('hAAA, 'h555, 'h555, 'hAAA);
		drain();

		// Random phases under changing thresholds and idling
		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 2) begin
				tx_idle_pct = 77;
				rx_idle_pct = 13;
			end
			if (ph == 4) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			case (ph)
				0: set_thresholds(CFG_DATA_W'(MIN_TOTAL_RST), CFG_DATA_W'(SAT_RST),
					CFG_DATA_W'(OPEN_RST), CFG_DATA_W'(SHORT_RST));
				2: set_thresholds('1, '1, '1, '1);
				4: set_thresholds(14'($urandom), 14'($urandom), 14'($urandom),
					14'($urandom));
				default: set_thresholds(14'($urandom_range(16380)), 14'($urandom_range(4095)),
					14'($urandom_range(4095)), 14'($urandom_range(4096)));
			endcase
			repeat (PHASE_ITEMS) begin
				reading_q.push_back(pick_reading());
				n_queued++;
			end
			drain();
		end

		// Let any stray output show up, then close
		repeat (TAIL_CYCLES) @(posedge clk);
		if (imbalance_q.size() != 0)
			report_error($sformatf("%0d results never arrived", imbalance_q.size()));
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
